### design/scc_pkg.sv
// shared types and constants for the system control coprocessor
// no dependencies
package scc_pkg;

    typedef enum logic [3:0] {
        ACT_READ    = 4'd0,
        ACT_WRITE   = 4'd1,
        ACT_TICK    = 4'd2,
        ACT_EXC     = 4'd3,
        ACT_ERET    = 4'd4,
        ACT_TLBR    = 4'd5,
        ACT_TLBWI   = 4'd6,
        ACT_TLBP    = 4'd7,
        ACT_BADADDR = 4'd8,
        ACT_USABLE  = 4'd9,
        ACT_IRQ     = 4'd10
    } action_t;

    localparam logic [4:0] REG_INDEX    = 5'd0;
    localparam logic [4:0] REG_LO0      = 5'd2;
    localparam logic [4:0] REG_LO1      = 5'd3;
    localparam logic [4:0] REG_CONTEXT  = 5'd4;
    localparam logic [4:0] REG_PAGEMASK = 5'd5;
    localparam logic [4:0] REG_BADVADDR = 5'd8;
    localparam logic [4:0] REG_COUNT    = 5'd9;
    localparam logic [4:0] REG_ENTRYHI  = 5'd10;
    localparam logic [4:0] REG_COMPARE  = 5'd11;
    localparam logic [4:0] REG_STATUS   = 5'd12;
    localparam logic [4:0] REG_CAUSE    = 5'd13;
    localparam logic [4:0] REG_EPC      = 5'd14;
    localparam logic [4:0] REG_ERROREPC = 5'd30;

    localparam logic [31:0] STATUS_RESET  = 32'h0040_0004;
    localparam logic [31:0] STATUS_MASK   = 32'hFF57_FFFF;
    localparam logic [31:0] ENTRYHI_MASK  = 32'hFFFF_E0FF;
    localparam logic [31:0] PAGEMASK_MASK = 32'h01FF_E000;
    localparam logic [31:0] VEC_BOOT      = 32'hBFC0_0200;
    localparam logic [31:0] VEC_NORMAL    = 32'h8000_0000;
    localparam logic [31:0] VEC_OFFSET    = 32'h0000_0180;
    localparam logic [31:0] PROBE_MISS    = 32'h8000_0000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic exec;
        logic probe_start;
        logic probe_step;
    } scc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_probe;
        logic probe_done;
    } scc_stat_t;

endpackage

### design/scc_ctrl.sv
// controller state machine for the system control coprocessor
// depends on scc_pkg
module scc_ctrl
    import scc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output scc_cmd_t  cmd,
    input  scc_stat_t stat
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (stat.is_probe)
                    begin
                        cmd.probe_start = 1'b1;
                        state_next = ST_PROBE;
                    end
                    else
                    begin
                        cmd.exec = 1'b1;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_PROBE:
            begin
                cmd.probe_step = 1'b1;
                if (stat.probe_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### design/scc_datapath.sv
// cp0 registers, tlb store and per-action update logic
// depends on scc_pkg
module scc_datapath
    import scc_pkg::*;
#(
    parameter int TLB_ENTRIES = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [3:0]  action,
    input  logic [4:0]  reg_index,
    input  logic [31:0] value,
    input  logic [4:0]  exc_code,
    input  logic [31:0] cur_pc,
    input  logic        in_delay_slot,
    input  logic [31:0] branch_addr,
    input  logic [1:0]  cop_number,
    input  logic        ext_irq,
    input  scc_cmd_t    cmd,
    output scc_stat_t   stat,
    output logic [31:0] read_data,
    output logic [31:0] next_pc,
    output logic        pc_redirect,
    output logic        cop_usable,
    output logic        irq_request,
    output logic        fpu_full_regs
);

    localparam int IW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

    logic [31:0] index_reg, context_reg, badv_reg, count_reg, hi_reg, compare_reg;
    logic [31:0] status_reg, cause_reg, epc_reg, errepc_reg;
    logic [25:0] lo0_reg, lo1_reg;
    logic [24:0] mask_reg;
    logic [31:0] rdata_reg, npc_reg;
    logic        redir_reg, usable_reg;

    logic [31:0] tlb_hi [TLB_ENTRIES];
    logic [25:0] tlb_lo0 [TLB_ENTRIES];
    logic [25:0] tlb_lo1 [TLB_ENTRIES];
    logic [24:0] tlb_mask [TLB_ENTRIES];

    logic [IW-1:0] probe_ptr_reg;
    logic [IW:0]   probe_cnt_reg;
    logic          probe_hit;

    logic [5:0]    slot_no;
    logic          slot_ok;
    logic [IW-1:0] slot_idx;

    assign slot_no  = index_reg[5:0];
    assign slot_ok  = {26'd0, slot_no} < 32'(TLB_ENTRIES);
    assign slot_idx = slot_no[IW-1:0];

    assign probe_hit = tlb_hi[probe_ptr_reg] == hi_reg;
    assign stat.is_probe = action == ACT_TLBP;
    assign stat.probe_done = probe_hit || (probe_cnt_reg == (IW+1)'(TLB_ENTRIES - 1));

    logic [31:0] rd_mux;
    always_comb
    begin
        unique case (reg_index)
            REG_INDEX:    rd_mux = index_reg;
            REG_LO0:      rd_mux = {6'd0, lo0_reg};
            REG_LO1:      rd_mux = {6'd0, lo1_reg};
            REG_CONTEXT:  rd_mux = context_reg;
            REG_PAGEMASK: rd_mux = {7'd0, mask_reg};
            REG_BADVADDR: rd_mux = badv_reg;
            REG_COUNT:    rd_mux = count_reg;
            REG_ENTRYHI:  rd_mux = hi_reg;
            REG_COMPARE:  rd_mux = compare_reg;
            REG_STATUS:   rd_mux = status_reg;
            REG_CAUSE:    rd_mux = cause_reg;
            REG_EPC:      rd_mux = epc_reg;
            REG_ERROREPC: rd_mux = errepc_reg;
            default:      rd_mux = 32'd0;
        endcase
    end

    logic [31:0] count_inc;
    assign count_inc = count_reg + 32'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg <= '0; context_reg <= '0; badv_reg <= '0; count_reg <= '0;
            hi_reg <= '0; compare_reg <= '0; status_reg <= STATUS_RESET;
            cause_reg <= '0; epc_reg <= '0; errepc_reg <= '0;
            lo0_reg <= '0; lo1_reg <= '0; mask_reg <= '0;
            probe_ptr_reg <= '0; probe_cnt_reg <= '0;
            for (int i = 0; i < TLB_ENTRIES; i++)
            begin
                tlb_hi[i] <= '0; tlb_lo0[i] <= '0; tlb_lo1[i] <= '0; tlb_mask[i] <= '0;
            end
        end
        else if (cmd.probe_start)
        begin
            probe_ptr_reg <= '0;
            probe_cnt_reg <= '0;
            rdata_reg <= '0; npc_reg <= '0; redir_reg <= 1'b0; usable_reg <= 1'b0;
        end
        else if (cmd.probe_step)
        begin
            if (probe_hit)
                index_reg <= {{(32-IW){1'b0}}, probe_ptr_reg};
            else if (stat.probe_done)
                index_reg <= PROBE_MISS;
            probe_ptr_reg <= probe_ptr_reg + IW'(1);
            probe_cnt_reg <= probe_cnt_reg + (IW+1)'(1);
        end
        else if (cmd.exec)
        begin
            rdata_reg <= '0; npc_reg <= '0; redir_reg <= 1'b0; usable_reg <= 1'b0;
            case (action)
                ACT_READ: rdata_reg <= rd_mux;
                ACT_WRITE:
                    case (reg_index)
                        REG_INDEX:    index_reg <= {26'd0, value[5:0]};
                        REG_LO0:      lo0_reg <= value[25:0];
                        REG_LO1:      lo1_reg <= value[25:0];
                        REG_CONTEXT:  context_reg <= {value[31:4], 4'd0};
                        REG_PAGEMASK: mask_reg <= value[24:0] & PAGEMASK_MASK[24:0];
                        REG_COUNT:    count_reg <= value;
                        REG_ENTRYHI:  hi_reg <= value & ENTRYHI_MASK;
                        REG_COMPARE:
                        begin
                            compare_reg <= value;
                            cause_reg[15] <= 1'b0;
                        end
                        REG_STATUS:
                        begin
                            status_reg <= value & STATUS_MASK;
                            cause_reg[10] <= ext_irq;
                        end
                        REG_CAUSE:
                        begin
                            cause_reg[9:8] <= value[9:8];
                            cause_reg[10] <= ext_irq;
                        end
                        REG_EPC:      epc_reg <= value;
                        REG_ERROREPC: errepc_reg <= value;
                        default: ;
                    endcase
                ACT_TICK:
                begin
                    count_reg <= count_inc;
                    if (count_inc == compare_reg)
                    begin
                        cause_reg[15] <= 1'b1;
                        cause_reg[10] <= ext_irq;
                    end
                end
                ACT_EXC:
                begin
                    status_reg[1] <= 1'b1;
                    cause_reg[31] <= in_delay_slot;
                    cause_reg[6:2] <= exc_code;
                    if (in_delay_slot)
                        epc_reg <= branch_addr - 32'd4;
                    else if (exc_code != 5'd0)
                        epc_reg <= cur_pc - 32'd4;
                    else
                        epc_reg <= cur_pc;
                    npc_reg <= (status_reg[22] ? VEC_BOOT : VEC_NORMAL)
                             + ((exc_code[4:1] == 4'd1) ? 32'd0 : VEC_OFFSET);
                    redir_reg <= 1'b1;
                end
                ACT_ERET:
                begin
                    if (status_reg[2])
                    begin
                        npc_reg <= errepc_reg;
                        status_reg[2] <= 1'b0;
                    end
                    else
                    begin
                        npc_reg <= epc_reg;
                        status_reg[1] <= 1'b0;
                    end
                    redir_reg <= 1'b1;
                end
                ACT_TLBR:
                    if (slot_ok)
                    begin
                        lo0_reg <= tlb_lo0[slot_idx];
                        lo1_reg <= tlb_lo1[slot_idx];
                        hi_reg <= tlb_hi[slot_idx];
                        mask_reg <= tlb_mask[slot_idx];
                    end
                ACT_TLBWI:
                    if (slot_ok)
                    begin
                        tlb_lo0[slot_idx] <= lo0_reg;
                        tlb_lo1[slot_idx] <= lo1_reg;
                        tlb_hi[slot_idx] <= hi_reg;
                        tlb_mask[slot_idx] <= mask_reg;
                    end
                ACT_BADADDR:
                begin
                    badv_reg <= value;
                    hi_reg <= {value[31:13], 13'd0};
                    context_reg[22:4] <= value[31:13];
                end
                ACT_USABLE:
                begin
                    usable_reg <= 1'b1;
                    if (!status_reg[28 + cop_number] && (cop_number != 2'd0 ||
                        (status_reg[2:1] == 2'd0 && status_reg[4:3] != 2'd0)))
                    begin
                        cause_reg[29:28] <= cop_number;
                        usable_reg <= 1'b0;
                    end
                end
                ACT_IRQ: cause_reg[10] <= ext_irq;
                default: ;
            endcase
        end
    end

    assign read_data = rdata_reg;
    assign next_pc = npc_reg;
    assign pc_redirect = redir_reg;
    assign cop_usable = usable_reg;
    assign irq_request = (status_reg[2:0] == 3'b001) && ((status_reg[15:8] & cause_reg[15:8]) != 8'd0);
    assign fpu_full_regs = status_reg[26];

endmodule

### design/system_control_coprocessor_core.sv
// a non-probe result is valid in the cycle after the input transaction
// no new input until the result is taken; a probe walks one tlb entry per cycle
// reset: rst_n async low; status to 0x400004, other cp0 regs and tlb to zero
// depends on scc_pkg, scc_ctrl, scc_datapath
module system_control_coprocessor_core
    import scc_pkg::*;
#(
    parameter int TLB_ENTRIES = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // action[3:0], reg_index[8:4], value[40:9], exc_code[45:41], cur_pc[77:46],
    // in_delay_slot[78], branch_addr[110:79], cop_number[112:111], ext_irq[113]
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // read_data[31:0], next_pc[63:32], pc_redirect[64], cop_usable[65],
    // irq_request[66], fpu_full_regs[67]
    output logic [71:0]  m_tdata
);

    scc_cmd_t  cmd;
    scc_stat_t stat;

    scc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .cmd(cmd), .stat(stat)
    );

    scc_datapath #(.TLB_ENTRIES(TLB_ENTRIES)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .action(s_tdata[3:0]), .reg_index(s_tdata[8:4]), .value(s_tdata[40:9]),
        .exc_code(s_tdata[45:41]), .cur_pc(s_tdata[77:46]),
        .in_delay_slot(s_tdata[78]), .branch_addr(s_tdata[110:79]),
        .cop_number(s_tdata[112:111]), .ext_irq(s_tdata[113]),
        .cmd(cmd), .stat(stat),
        .read_data(m_tdata[31:0]), .next_pc(m_tdata[63:32]),
        .pc_redirect(m_tdata[64]), .cop_usable(m_tdata[65]),
        .irq_request(m_tdata[66]), .fpu_full_regs(m_tdata[67])
    );

    assign m_tdata[71:68] = 4'd0;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid)) else $error("input taken while result pending");
    a_redirect_pc: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[64]) |-> m_tdata[63:32] == 32'd0)
        else $error("next_pc without redirect");
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.exec, cmd.probe_start, cmd.probe_step}))
        else $error("conflicting commands");

endmodule
